@@ hdl/plcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcr_pkg: shared types and codes for the colour ramp
// Word formats, status and request codes, and the state types.
// ----------------------------------------------------------------------------
package plcr_pkg;

    localparam int MAX_STOPS_DEF = 16;
    localparam int KEY_W         = 32;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] key;
        logic [7:0]              red_in;
        logic [7:0]              green_in;
        logic [7:0]              blue_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [1:0] status;
    } out_word_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_LOOK,
        T_WAIT,
        T_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        LP_IDLE,
        LP_MUL,
        LP_SUM,
        LP_DIV,
        LP_DONE
    } lerp_state_t;

endpackage

@@ hdl/plcr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcr_cell: one colour stop of the sorted chain
// Holds a key and colour, compares against the broadcast key and, on an
// insert, either keeps its stop, takes the new one or takes its neighbour's.
// ----------------------------------------------------------------------------
module plcr_cell
    import plcr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    ins_en,
    input  logic                    occupied,
    input  logic signed [KEY_W-1:0] cmp_key,
    input  rgb_t                    new_color,
    input  logic signed [KEY_W-1:0] left_key,
    input  rgb_t                    left_color,
    input  logic                    left_le,
    output logic signed [KEY_W-1:0] key,
    output rgb_t                    color,
    output logic                    le
);

    logic signed [KEY_W-1:0] key_reg;
    rgb_t                    color_reg;

    // An occupied stop at or below the broadcast key stays where it is.
    assign le    = occupied && (key_reg <= cmp_key);
    assign key   = key_reg;
    assign color = color_reg;

    // Cells above the insert point move up by one; the first of them takes
    // the new stop.
    always_ff @(posedge aclk) begin
        if (ins_en && !le) begin
            if (left_le) begin
                key_reg   <= cmp_key;
                color_reg <= new_color;
            end else begin
                key_reg   <= left_key;
                color_reg <= left_color;
            end
        end
    end

endmodule

@@ hdl/plcr_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcr_lerp: interpolation between two stops
// Forms the weighted sum per channel and divides it by the key span with a
// restoring divider, one quotient bit per cycle for all three channels.
// ----------------------------------------------------------------------------
module plcr_lerp
    import plcr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [KEY_W-1:0] v,
    input  logic signed [KEY_W-1:0] k0,
    input  logic signed [KEY_W-1:0] k1,
    input  rgb_t                    c0,
    input  rgb_t                    c1,
    output logic                    done,
    output rgb_t                    result
);

    localparam int PW = KEY_W + 8;   // one product
    localparam int NW = PW + 1;      // sum of two products

    lerp_state_t st_reg, st_next;
    logic [2:0]       bit_reg;
    logic [KEY_W-1:0] dhi_reg, dlo_reg, den_reg;
    logic [7:0]       a_reg [3];
    logic [7:0]       z_reg [3];
    logic [PW-1:0]    pa_reg [3];
    logic [PW-1:0]    pz_reg [3];
    logic [NW-1:0]    rem_reg [3];
    logic [NW-1:0]    dsh_reg;
    logic [7:0]       q_reg [3];
    logic signed [KEY_W:0] dhi_w, dlo_w, den_w;

    assign dhi_w = {k1[KEY_W-1], k1} - {v[KEY_W-1], v};
    assign dlo_w = {v[KEY_W-1], v} - {k0[KEY_W-1], k0};
    assign den_w = {k1[KEY_W-1], k1} - {k0[KEY_W-1], k0};

    // Next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            LP_IDLE: if (start) st_next = LP_MUL;
            LP_MUL:  st_next = LP_SUM;
            LP_SUM:  st_next = LP_DIV;
            LP_DIV:  if (bit_reg == 3'd0) st_next = LP_DONE;
            LP_DONE: st_next = LP_IDLE;
            default: st_next = LP_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        done     = (st_reg == LP_DONE);
        result.r = q_reg[0];
        result.g = q_reg[1];
        result.b = q_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= LP_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // Datapath: differences, products, sum, then the divide steps.
    always_ff @(posedge aclk) begin
        logic [NW:0] trial;
        case (st_reg)
            LP_IDLE: begin
                dhi_reg  <= dhi_w[KEY_W-1:0];
                dlo_reg  <= dlo_w[KEY_W-1:0];
                den_reg  <= den_w[KEY_W-1:0];
                a_reg[0] <= c0.r;
                a_reg[1] <= c0.g;
                a_reg[2] <= c0.b;
                z_reg[0] <= c1.r;
                z_reg[1] <= c1.g;
                z_reg[2] <= c1.b;
            end
            LP_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    pa_reg[c] <= PW'(a_reg[c]) * PW'(dhi_reg);
                    pz_reg[c] <= PW'(z_reg[c]) * PW'(dlo_reg);
                end
            end
            LP_SUM: begin
                for (int c = 0; c < 3; c++) begin
                    rem_reg[c] <= NW'(pa_reg[c]) + NW'(pz_reg[c]);
                end
                dsh_reg <= NW'({den_reg, 7'd0});
                bit_reg <= 3'd7;
            end
            LP_DIV: begin
                for (int c = 0; c < 3; c++) begin
                    trial = {1'b0, rem_reg[c]} - {1'b0, dsh_reg};
                    if (!trial[NW]) begin
                        rem_reg[c] <= trial[NW-1:0];
                    end
                    q_reg[c] <= {q_reg[c][6:0], ~trial[NW]};
                end
                dsh_reg <= dsh_reg >> 1;
                bit_reg <= bit_reg - 3'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/piecewise_linear_color_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_color_ramp: sorted colour stops with linear lookup
// A chain of stop cells kept in key order, a sequencer, and an interpolator.
// ----------------------------------------------------------------------------
//  Channel  | Ports                     | Word
//  input    | s_valid s_ready s_data    | in_word_t  (insert or lookup)
//  result   | m_valid m_ready m_data    | out_word_t (colour and status)
//
//  On an insert the cells shift in the cycle the word is taken.
//  A lookup that clamps or finds the table empty skips the interpolator; one
//  that interpolates goes through intake, difference, multiply, sum, 8
//  divider steps, finish, then hand-off.
//  A new word is taken while the previous result still waits for m_ready.
//  Reset empties the table at once; the stop contents are not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_color_ramp
    import plcr_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CW   = $clog2(MAX_STOPS + 1);
    localparam int IDXW = $clog2(MAX_STOPS);

    top_state_t st_reg, st_next;
    logic [CW-1:0]           count_reg;
    logic signed [KEY_W-1:0] v_reg;
    out_word_t               res_reg, res_next;
    logic                    m_valid_reg;
    out_word_t               m_data_reg;

    logic                    accept, full, ins_en, lerp_start, lerp_done, out_load;
    logic signed [KEY_W-1:0] cmp_key;
    rgb_t                    new_color, lerp_res;
    logic [CW-1:0]           cnt_m1;

    logic signed [KEY_W-1:0] cell_key   [MAX_STOPS];
    rgb_t                    cell_color [MAX_STOPS];
    logic [MAX_STOPS-1:0]    cell_le, cell_occ;

    logic signed [KEY_W-1:0] k0_sel, k1_sel;
    rgb_t                    c0_sel, c1_sel, last_color;
    logic                    lo_clamp, hi_clamp;

    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CW'(MAX_STOPS));
    assign cmp_key   = (st_reg == T_IDLE) ? s_data.key : v_reg;
    assign new_color = '{r: s_data.red_in, g: s_data.green_in, b: s_data.blue_in};
    assign cnt_m1    = count_reg - CW'(1);

    // Chain of stop cells, each looking only at its left neighbour.
    for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
        assign cell_occ[i] = (CW'(i) < count_reg);
        if (i == 0) begin : g_first
            plcr_cell u_cell (
                .aclk      (aclk),
                .ins_en    (ins_en),
                .occupied  (cell_occ[i]),
                .cmp_key   (cmp_key),
                .new_color (new_color),
                .left_key  (cmp_key),
                .left_color(new_color),
                .left_le   (1'b1),
                .key       (cell_key[i]),
                .color     (cell_color[i]),
                .le        (cell_le[i])
            );
        end else begin : g_rest
            plcr_cell u_cell (
                .aclk      (aclk),
                .ins_en    (ins_en),
                .occupied  (cell_occ[i]),
                .cmp_key   (cmp_key),
                .new_color (new_color),
                .left_key  (cell_key[i-1]),
                .left_color(cell_color[i-1]),
                .left_le   (cell_le[i-1]),
                .key       (cell_key[i]),
                .color     (cell_color[i]),
                .le        (cell_le[i])
            );
        end
    end

    // Pick the bracketing pair and the last stop from the compare results.
    always_comb begin
        k0_sel     = '0;
        k1_sel     = '0;
        c0_sel     = '0;
        c1_sel     = '0;
        last_color = '0;
        hi_clamp   = 1'b0;
        for (int i = 0; i < MAX_STOPS; i++) begin
            if (cnt_m1[IDXW-1:0] == IDXW'(i)) begin
                last_color = last_color | cell_color[i];
                hi_clamp   = hi_clamp | cell_le[i];
            end
        end
        for (int i = 1; i < MAX_STOPS; i++) begin
            if (cell_le[i-1] && !cell_le[i] && cell_occ[i]) begin
                k0_sel = k0_sel | cell_key[i-1];
                k1_sel = k1_sel | cell_key[i];
                c0_sel = c0_sel | cell_color[i-1];
                c1_sel = c1_sel | cell_color[i];
            end
        end
        lo_clamp = (v_reg <= cell_key[0]);
    end

    plcr_lerp u_lerp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (lerp_start),
        .v      (v_reg),
        .k0     (k0_sel),
        .k1     (k1_sel),
        .c0     (c0_sel),
        .c1     (c1_sel),
        .done   (lerp_done),
        .result (lerp_res)
    );

    // Next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            T_IDLE: begin
                if (accept) begin
                    st_next = (s_data.req_type == REQ_LOOKUP) ? T_LOOK : T_DONE;
                end
            end
            T_LOOK: begin
                if (count_reg != '0 && !lo_clamp && !hi_clamp) begin
                    st_next = T_WAIT;
                end else begin
                    st_next = T_DONE;
                end
            end
            T_WAIT:  if (lerp_done) st_next = T_DONE;
            T_DONE:  if (!m_valid_reg || m_ready) st_next = T_IDLE;
            default: st_next = T_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready    = 1'b0;
        ins_en     = 1'b0;
        lerp_start = 1'b0;
        out_load   = 1'b0;
        res_next   = res_reg;
        unique case (st_reg)
            T_IDLE: begin
                s_ready = 1'b1;
                if (accept && s_data.req_type == REQ_INSERT) begin
                    ins_en   = !full;
                    res_next = '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                                 status: full ? ST_FULL : ST_OK};
                end
            end
            T_LOOK: begin
                priority if (count_reg == '0) begin
                    res_next = '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                                 status: ST_EMPTY};
                end else if (lo_clamp) begin
                    res_next = '{red_out: cell_color[0].r, green_out: cell_color[0].g,
                                 blue_out: cell_color[0].b, status: ST_OK};
                end else if (hi_clamp) begin
                    res_next = '{red_out: last_color.r, green_out: last_color.g,
                                 blue_out: last_color.b, status: ST_OK};
                end else begin
                    lerp_start = 1'b1;
                end
            end
            T_WAIT: begin
                if (lerp_done) begin
                    res_next = '{red_out: lerp_res.r, green_out: lerp_res.g,
                                 blue_out: lerp_res.b, status: ST_OK};
                end
            end
            T_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= T_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (ins_en) begin
                count_reg <= count_reg + CW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            v_reg <= s_data.key;
        end
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/plcr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcr_checker: port-level checks for the colour ramp
// Watches the handshakes and result words and flags inconsistent behaviour.
// ----------------------------------------------------------------------------
module plcr_checker
    import plcr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // A stalled result word stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    // One word at a time: taking a word closes the input side.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again while a word is in progress");

    // Only defined status codes appear.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_FULL ||
                     m_data.status == ST_EMPTY))
        else $error("undefined status code");

    // Refused inserts and empty lookups give black.
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.red_out == 8'd0 && m_data.green_out == 8'd0 &&
            m_data.blue_out == 8'd0)
        else $error("non-black colour with an error status");

endmodule

bind piecewise_linear_color_ramp plcr_checker u_plcr_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

@@ tb/tb_piecewise_linear_color_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_color_ramp: self-checking bench for the colour ramp
// Drives insert and lookup words with random gaps, predicts every result word
// from a local model of the sorted stop table, and checks the result words in
// order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_color_ramp;
    import plcr_pkg::*;

    localparam int STOPS = MAX_STOPS_DEF;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    piecewise_linear_color_ramp dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Local copy of the stop table.
    logic signed [31:0] ramp_keys [STOPS];
    rgb_t               ramp_cols [STOPS];
    int                 ramp_count;

    out_word_t colour_queue[$];
    int        error_count;
    bit        hold_off;
    bit        mute_stalls;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // One interpolated channel, computed exactly in 64 bits.
    function automatic logic [7:0] blend(input logic [7:0] c0, input logic [7:0] c1,
                                         input longint d_hi, input longint d_lo,
                                         input longint span);
        longint num;
        num = longint'(c0) * d_hi + longint'(c1) * d_lo;
        return 8'(num / span);
    endfunction

    // Updates the table and returns the expected result word.
    function automatic out_word_t predict_colour(input in_word_t w);
        out_word_t res;
        int        pos;
        int        i;
        int        last;
        longint    kv;
        rgb_t      c;
        res = '0;
        kv  = longint'(w.key);
        if (w.req_type == REQ_INSERT) begin
            if (ramp_count >= STOPS) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < ramp_count && ramp_keys[pos] <= w.key) pos++;
                for (i = ramp_count; i > pos; i--) begin
                    ramp_keys[i] = ramp_keys[i-1];
                    ramp_cols[i] = ramp_cols[i-1];
                end
                ramp_keys[pos] = w.key;
                ramp_cols[pos] = '{w.red_in, w.green_in, w.blue_in};
                ramp_count++;
            end
        end else if (ramp_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            last = ramp_count - 1;
            if (w.key <= ramp_keys[0] || w.key >= ramp_keys[last]) begin
                c = (w.key <= ramp_keys[0]) ? ramp_cols[0] : ramp_cols[last];
                res.red_out = c.r; res.green_out = c.g; res.blue_out = c.b;
            end else begin
                i = 1;
                while (i < last && ramp_keys[i] <= w.key) i++;
                res.red_out   = blend(ramp_cols[i-1].r, ramp_cols[i].r,
                    longint'(ramp_keys[i]) - kv, kv - longint'(ramp_keys[i-1]),
                    longint'(ramp_keys[i]) - longint'(ramp_keys[i-1]));
                res.green_out = blend(ramp_cols[i-1].g, ramp_cols[i].g,
                    longint'(ramp_keys[i]) - kv, kv - longint'(ramp_keys[i-1]),
                    longint'(ramp_keys[i]) - longint'(ramp_keys[i-1]));
                res.blue_out  = blend(ramp_cols[i-1].b, ramp_cols[i].b,
                    longint'(ramp_keys[i]) - kv, kv - longint'(ramp_keys[i-1]),
                    longint'(ramp_keys[i]) - longint'(ramp_keys[i-1]));
            end
        end
        return res;
    endfunction

    // Sends one word after a random gap and records its expected result.
    // Valid stays high after the handshake so that a word with no gap follows
    // directly; each test drops valid after its last word.
    task automatic send_word(input logic req, input logic signed [31:0] k,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input bit no_gap = 0);
        in_word_t w;
        int       gap;
        w   = '{req, k, r, g, b};
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        colour_queue = {colour_queue, predict_colour(w)};
    endtask

    task automatic wait_drained();
        while (colour_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2:       return $signed($urandom_range(0, 64)) - 32;
            default: return $signed($urandom_range(0, 4000)) - 2000;
        endcase
    endfunction

    // Drives a sequence of lookups against the current table.
    task automatic random_lookups(input int n);
        int i;
        int j;
        for (i = 0; i < n; i++) begin
            if (ramp_count > 0 && $urandom_range(0, 2) == 0) begin
                j = $urandom_range(0, ramp_count - 1);
                send_word(REQ_LOOKUP, ramp_keys[j] + $signed($urandom_range(0, 6)) - 3,
                          8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_word(REQ_LOOKUP, rand_key(), 8'($urandom), 8'($urandom),
                          8'($urandom));
            end
        end
        s_valid <= 1'b0;
    endtask

    // Empty table, single stop, clamps, equal keys, extremes and a full table.
    task automatic test_directed();
        int i;
        send_word(REQ_LOOKUP, 32'sh0, 8'hff, 8'hff, 8'hff);
        send_word(REQ_INSERT, 32'sh0001_0000, 8'hff, 8'h80, 8'h00);
        send_word(REQ_LOOKUP, 32'sh8000_0000, 8'h00, 8'h00, 8'h00);
        send_word(REQ_LOOKUP, 32'sh7fff_ffff, 8'h00, 8'h00, 8'h00);
        send_word(REQ_INSERT, 32'sh8000_0000, 8'h00, 8'hff, 8'h01);
        send_word(REQ_INSERT, 32'sh7fff_ffff, 8'hff, 8'hff, 8'hff);
        send_word(REQ_LOOKUP, 32'sh0, 8'h00, 8'h00, 8'h00);
        send_word(REQ_LOOKUP, 32'sh7fff_fffe, 8'h00, 8'h00, 8'h00);
        send_word(REQ_LOOKUP, 32'sh8000_0001, 8'h00, 8'h00, 8'h00);
        send_word(REQ_INSERT, 32'sh0001_0000, 8'h00, 8'h00, 8'hff);
        send_word(REQ_LOOKUP, 32'sh0001_0000, 8'h00, 8'h00, 8'h00);
        send_word(REQ_LOOKUP, 32'sh0000_ffff, 8'h00, 8'h00, 8'h00);
        for (i = 0; i < 13; i++)
            send_word(REQ_INSERT, $signed(i) <<< 12, 8'($urandom), 8'($urandom),
                      8'($urandom));
        send_word(REQ_INSERT, 32'sh0, 8'h55, 8'haa, 8'h55);
        send_word(REQ_LOOKUP, 32'sh0000_0800, 8'h00, 8'h00, 8'h00);
        s_valid <= 1'b0;
        wait_drained();
    endtask

    // Random lookups against the table; it only grows, so it is full by now.
    task automatic test_random(input int n);
        random_lookups(n);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering words.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_lookups(30);
        join
        wait_drained();
    endtask

    // Back-to-back words with no gaps.
    task automatic test_streaming();
        int i;
        mute_stalls = 1'b1;
        for (i = 0; i < 60; i++)
            send_word(REQ_LOOKUP, rand_key(), 8'h00, 8'h00, 8'h00, 1);
        mute_stalls = 1'b0;
        s_valid <= 1'b0;
        wait_drained();
    endtask

    // Receiver: random stalls per result word, compared with the oldest expectation.
    initial begin
        int        stall;
        out_word_t want;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (colour_queue.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = colour_queue.pop_front();
                    if (m_data.red_out !== want.red_out)
                        report_mismatch("red", int'(m_data.red_out), int'(want.red_out));
                    if (m_data.green_out !== want.green_out)
                        report_mismatch("green", int'(m_data.green_out),
                                        int'(want.green_out));
                    if (m_data.blue_out !== want.blue_out)
                        report_mismatch("blue", int'(m_data.blue_out), int'(want.blue_out));
                    if (m_data.status !== want.status)
                        report_mismatch("status", int'(m_data.status), int'(want.status));
                end
                stall = mute_stalls ? 0 : $urandom_range(0, 3);
                if (stall != 0 || hold_off) m_ready <= 1'b0;
                else m_ready <= 1'b1;
            end else if (!hold_off && aresetn) begin
                if (stall > 0) stall--;
                else m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
            end
        end
    end

    initial begin
        error_count = 0;
        hold_off    = 1'b0;
        mute_stalls = 1'b0;
        ramp_count  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_streaming();
        test_random(700);
        repeat (50) @(posedge aclk);
        if (error_count == 0 && colour_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/plcr_pkg.sv
hdl/plcr_cell.sv
hdl/plcr_lerp.sv
hdl/piecewise_linear_color_ramp.sv
hdl/plcr_checker.sv
tb/tb_piecewise_linear_color_ramp.sv
